// ----- hw/rtl/lom_pkg.sv -----
// ----------------------------------------------------------------------------
// lom_pkg
// Types and codes shared by the limit order matcher and its sub-blocks.
// ----------------------------------------------------------------------------
package lom_pkg;

    typedef struct packed {
        logic        order_side;
        logic [31:0] order_price;
        logic [30:0] order_quantity;
        logic [31:0] order_ident;
        logic [31:0] order_time;
    } t_order;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [31:0] result_price;
        logic [30:0] result_quantity;
        logic [1:0]  level_action;
        logic        last_result;
    } t_result;

    // one resting order as held in the book memory
    typedef struct packed {
        logic [31:0] price;
        logic [30:0] qty;
        logic [31:0] ident;
        logic [31:0] time_s;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    localparam logic [2:0] KIND_TRADE   = 3'd0;
    localparam logic [2:0] KIND_BID     = 3'd1;
    localparam logic [2:0] KIND_ASK     = 3'd2;
    localparam logic [2:0] KIND_INVALID = 3'd3;
    localparam logic [2:0] KIND_FULL    = 3'd4;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_MODIFY = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    localparam logic [30:0] QTY_MAX = 31'h7FFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_SCAN,
        S_FILL,
        S_FREE,
        S_REST,
        S_LVL_RD,
        S_LVL_SCAN,
        S_LVL_EMIT
    } t_state;

endpackage

// ----- hw/rtl/lom_stream_if.sv -----
// ----------------------------------------------------------------------------
// lom_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface lom_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/lom_mem.sv -----
// ----------------------------------------------------------------------------
// lom_mem
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lom_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

// ----- hw/rtl/lom_out_reg.sv -----
// ----------------------------------------------------------------------------
// lom_out_reg
// Result output register; holds a beat until the sink takes it.
// ----------------------------------------------------------------------------
module lom_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lom_pkg::t_result i_data,
    output logic             o_can_push,
    lom_stream_if.source     o_result
);
    logic             r_valid;
    lom_pkg::t_result r_data;

    assign o_can_push = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_push) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_push && i_push) begin
            r_data <= i_data;
        end
    end

    assign o_result.valid = r_valid;
    assign o_result.data  = r_data;
endmodule

// ----- hw/rtl/limit_order_matcher.sv -----
// ----------------------------------------------------------------------------
// limit_order_matcher
// Price-time priority matcher over a bid and an ask book held in one RAM.
// ----------------------------------------------------------------------------
//  channel   dir  beat       payload
//  i_order   in   one order  side, price, quantity, ident, time
//  o_result  out  one result kind, price, quantity, level action, last flag
//
//  Per order: an accept step, then a book sweep for the best opposite entry
//  and a fill step, repeated for each fill while quantity remains and the
//  book crosses; then, if quantity remains, a free-slot sweep and the add,
//  and for each touched level a read, a sweep and an emit; the single book
//  RAM read port sets this. An invalid order goes straight to its error beat.
//  Reset empties both books at once. A stalled result output holds the
//  sequencer; one order is worked at a time.
// ----------------------------------------------------------------------------
module limit_order_matcher #(
    parameter int BOOK_DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lom_stream_if.sink   i_order,
    lom_stream_if.source o_result
);
    localparam int IW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
    localparam int CW = IW + 1;
    localparam int SW = 31 + IW;
    localparam logic [CW-1:0] DEPTH_C = CW'(BOOK_DEPTH);
    localparam logic [CW-1:0] LAST_C  = CW'(BOOK_DEPTH - 1);

    lom_pkg::t_state r_state, n_state;
    lom_pkg::t_order r_ord, n_ord;
    logic [30:0]     r_qty, n_qty;
    logic [CW-1:0]   r_idx, n_idx;
    logic [1:0][BOOK_DEPTH-1:0] r_valid, n_valid;
    logic [IW-1:0]   r_rank [2][BOOK_DEPTH];
    logic [IW-1:0]   n_rank [2][BOOK_DEPTH];
    logic            r_rd_v;
    logic [IW-1:0]   r_rd_rank, r_rd_idx;
    logic            r_bfound, n_bfound;
    logic [IW-1:0]   r_bidx, n_bidx, r_brank, n_brank;
    lom_pkg::t_entry r_bent, n_bent;
    logic [CW-1:0]   r_nseen, n_nseen, r_lvl, n_lvl;
    logic [31:0]     r_lastp, n_lastp;
    logic [SW-1:0]   r_sum, n_sum;
    logic            r_sfound, n_sfound;
    logic [IW-1:0]   r_slot, n_slot;
    logic [CW-1:0]   r_cnt, n_cnt;

    logic            own_s, opp_s;
    logic            in_acc, can_emit, emit;
    lom_pkg::t_result emit_data;
    logic            bk_we, bk_re;
    logic [IW:0]     bk_waddr, bk_raddr;
    lom_pkg::t_entry bk_wdata, bk_q;
    logic            sn_we, sn_re;
    logic [IW-1:0]   sn_waddr, sn_raddr;
    logic [31:0]     sn_q;
    logic [IW-1:0]   scan_idx;
    logic            better, crosses, last_lvl;
    logic [30:0]     sum_sat;
    logic [CW-1:0]   rev_idx;

    assign own_s   = r_ord.order_side;
    assign opp_s   = ~r_ord.order_side;
    assign in_acc  = i_order.valid && i_order.ready;
    assign i_order.ready = (r_state == lom_pkg::S_IDLE);
    assign scan_idx = r_idx[IW-1:0];
    assign crosses = (own_s == lom_pkg::SIDE_BUY) ? (r_bent.price <= r_ord.order_price)
                                                  : (r_bent.price >= r_ord.order_price);
    assign last_lvl = (r_lvl == r_nseen - CW'(1));
    assign sum_sat  = (|r_sum[SW-1:31]) ? lom_pkg::QTY_MAX : r_sum[30:0];
    assign rev_idx  = r_nseen - CW'(1) - r_lvl;

    // candidate vs current best: price, then time, then arrival rank
    always_comb begin
        if (!r_bfound) begin
            better = 1'b1;
        end else if (bk_q.price != r_bent.price) begin
            better = (own_s == lom_pkg::SIDE_SELL) ? (bk_q.price > r_bent.price)
                                                   : (bk_q.price < r_bent.price);
        end else if (bk_q.time_s != r_bent.time_s) begin
            better = bk_q.time_s < r_bent.time_s;
        end else begin
            better = r_rd_rank < r_brank;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lom_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_order.data.order_price == '0 || i_order.data.order_quantity == '0)
                        n_state = lom_pkg::S_ERR;
                    else
                        n_state = lom_pkg::S_SCAN;
                end
            end
            lom_pkg::S_ERR: begin
                if (can_emit) n_state = lom_pkg::S_IDLE;
            end
            lom_pkg::S_SCAN: begin
                if (r_idx == DEPTH_C) n_state = lom_pkg::S_FILL;
            end
            lom_pkg::S_FILL: begin
                if (!r_bfound || !crosses) begin
                    n_state = lom_pkg::S_FREE;
                end else if (can_emit) begin
                    if (r_bent.qty >= r_qty) n_state = lom_pkg::S_LVL_RD;
                    else                     n_state = lom_pkg::S_SCAN;
                end
            end
            lom_pkg::S_FREE: begin
                if (r_idx == LAST_C) n_state = lom_pkg::S_REST;
            end
            lom_pkg::S_REST: begin
                if (can_emit)
                    n_state = (r_nseen == '0) ? lom_pkg::S_IDLE : lom_pkg::S_LVL_RD;
            end
            lom_pkg::S_LVL_RD: n_state = lom_pkg::S_LVL_SCAN;
            lom_pkg::S_LVL_SCAN: begin
                if (r_idx == DEPTH_C) n_state = lom_pkg::S_LVL_EMIT;
            end
            lom_pkg::S_LVL_EMIT: begin
                if (can_emit) n_state = last_lvl ? lom_pkg::S_IDLE : lom_pkg::S_LVL_RD;
            end
            default: n_state = lom_pkg::S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_ord    = r_ord;
        n_qty    = r_qty;
        n_idx    = r_idx;
        n_valid  = r_valid;
        n_rank   = r_rank;
        n_bfound = r_bfound;
        n_bidx   = r_bidx;
        n_brank  = r_brank;
        n_bent   = r_bent;
        n_nseen  = r_nseen;
        n_lvl    = r_lvl;
        n_lastp  = r_lastp;
        n_sum    = r_sum;
        n_sfound = r_sfound;
        n_slot   = r_slot;
        n_cnt    = r_cnt;
        emit     = 1'b0;
        emit_data = '0;
        bk_we    = 1'b0;
        bk_waddr = {opp_s, r_bidx};
        bk_wdata = r_bent;
        bk_re    = 1'b0;
        bk_raddr = {opp_s, scan_idx};
        sn_we    = 1'b0;
        sn_waddr = r_nseen[IW-1:0];
        sn_re    = 1'b0;
        sn_raddr = (own_s == lom_pkg::SIDE_BUY) ? r_lvl[IW-1:0] : rev_idx[IW-1:0];

        case (r_state)
            lom_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_ord    = i_order.data;
                    n_qty    = i_order.data.order_quantity;
                    n_idx    = '0;
                    n_bfound = 1'b0;
                    n_nseen  = '0;
                    n_lvl    = '0;
                end
            end
            lom_pkg::S_ERR: begin
                emit = 1'b1;
                emit_data.result_kind = lom_pkg::KIND_INVALID;
                emit_data.last_result = 1'b1;
            end
            lom_pkg::S_SCAN, lom_pkg::S_LVL_SCAN: begin
                bk_re = (r_idx < DEPTH_C);
                n_idx = r_idx + CW'(1);
                if (r_idx != '0 && r_rd_v) begin
                    if (r_state == lom_pkg::S_SCAN) begin
                        if (better) begin
                            n_bfound = 1'b1;
                            n_bidx   = r_rd_idx;
                            n_brank  = r_rd_rank;
                            n_bent   = bk_q;
                        end
                    end else if (bk_q.price == sn_q) begin
                        n_sum = r_sum + SW'(bk_q.qty);
                    end
                end
            end
            lom_pkg::S_FILL: begin
                if (!r_bfound || !crosses) begin
                    n_idx    = '0;
                    n_cnt    = '0;
                    n_sfound = 1'b0;
                end else if (can_emit) begin
                    emit = 1'b1;
                    emit_data.result_kind  = lom_pkg::KIND_TRADE;
                    emit_data.result_price = r_bent.price;
                    n_idx    = '0;
                    n_bfound = 1'b0;
                    if (r_nseen == '0 || r_bent.price != r_lastp) begin
                        sn_we   = (r_nseen < DEPTH_C);
                        n_nseen = r_nseen + CW'(1);
                        n_lastp = r_bent.price;
                    end
                    if (r_bent.qty > r_qty) begin
                        emit_data.result_quantity = r_qty;
                        bk_we        = 1'b1;
                        bk_wdata.qty = r_bent.qty - r_qty;
                        n_qty        = '0;
                    end else begin
                        emit_data.result_quantity = r_bent.qty;
                        n_qty = r_qty - r_bent.qty;
                        n_valid[opp_s][r_bidx] = 1'b0;
                        for (int j = 0; j < BOOK_DEPTH; j++) begin
                            if (r_valid[opp_s][j] && r_rank[opp_s][j] > r_brank)
                                n_rank[opp_s][j] = r_rank[opp_s][j] - IW'(1);
                        end
                    end
                end
            end
            lom_pkg::S_FREE: begin
                n_idx = r_idx + CW'(1);
                if (r_valid[own_s][scan_idx]) begin
                    n_cnt = r_cnt + CW'(1);
                end else if (!r_sfound) begin
                    n_sfound = 1'b1;
                    n_slot   = scan_idx;
                end
            end
            lom_pkg::S_REST: begin
                emit = 1'b1;
                emit_data.last_result = (r_nseen == '0);
                if (r_sfound) begin
                    emit_data.result_kind = (own_s == lom_pkg::SIDE_BUY) ? lom_pkg::KIND_BID
                                                                         : lom_pkg::KIND_ASK;
                    emit_data.result_price    = r_ord.order_price;
                    emit_data.result_quantity = r_qty;
                    emit_data.level_action    = lom_pkg::ACT_ADD;
                    bk_waddr        = {own_s, r_slot};
                    bk_wdata.price  = r_ord.order_price;
                    bk_wdata.qty    = r_qty;
                    bk_wdata.ident  = r_ord.order_ident;
                    bk_wdata.time_s = r_ord.order_time;
                    if (can_emit) begin
                        bk_we = 1'b1;
                        n_valid[own_s][r_slot] = 1'b1;
                        n_rank[own_s][r_slot]  = r_cnt[IW-1:0];
                    end
                end else begin
                    emit_data.result_kind = lom_pkg::KIND_FULL;
                end
            end
            lom_pkg::S_LVL_RD: begin
                sn_re = 1'b1;
                n_idx = '0;
                n_sum = '0;
            end
            lom_pkg::S_LVL_EMIT: begin
                emit = 1'b1;
                emit_data.result_kind = (own_s == lom_pkg::SIDE_BUY) ? lom_pkg::KIND_ASK
                                                                     : lom_pkg::KIND_BID;
                emit_data.result_price    = sn_q;
                emit_data.result_quantity = sum_sat;
                emit_data.level_action    = (r_sum == '0) ? lom_pkg::ACT_DELETE
                                                          : lom_pkg::ACT_MODIFY;
                emit_data.last_result     = last_lvl;
                if (can_emit) n_lvl = r_lvl + CW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lom_pkg::S_IDLE;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ord     <= n_ord;
        r_qty     <= n_qty;
        r_idx     <= n_idx;
        r_rank    <= n_rank;
        r_bfound  <= n_bfound;
        r_bidx    <= n_bidx;
        r_brank   <= n_brank;
        r_bent    <= n_bent;
        r_nseen   <= n_nseen;
        r_lvl     <= n_lvl;
        r_lastp   <= n_lastp;
        r_sum     <= n_sum;
        r_sfound  <= n_sfound;
        r_slot    <= n_slot;
        r_cnt     <= n_cnt;
        // valid and rank are registered alongside the RAM read so they line up with its data
        r_rd_v    <= bk_re && r_valid[opp_s][scan_idx];
        r_rd_rank <= r_rank[opp_s][scan_idx];
        r_rd_idx  <= scan_idx;
    end

    lom_mem #(
        .DEPTH (2 * (1 << IW)),
        .WIDTH (lom_pkg::ENTRY_W)
    ) u_book (
        .i_clk   (i_clk),
        .i_we    (bk_we),
        .i_waddr (bk_waddr),
        .i_wdata (bk_wdata),
        .i_re    (bk_re),
        .i_raddr (bk_raddr),
        .o_rdata (bk_q)
    );

    lom_mem #(
        .DEPTH (1 << IW),
        .WIDTH (32)
    ) u_seen (
        .i_clk   (i_clk),
        .i_we    (sn_we),
        .i_waddr (sn_waddr),
        .i_wdata (r_bent.price),
        .i_re    (sn_re),
        .i_raddr (sn_raddr),
        .o_rdata (sn_q)
    );

    lom_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (emit && can_emit),
        .i_data     (emit_data),
        .o_can_push (can_emit),
        .o_result   (o_result)
    );
endmodule

// ----- hw/rtl/lom_checker.sv -----
// ----------------------------------------------------------------------------
// lom_checker
// Port-level checks for the limit order matcher, bound to the top level.
// ----------------------------------------------------------------------------
module lom_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input lom_pkg::t_result i_out_data
);
    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result beat changed while stalled");

    // one order at a time
    a_one_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("order taken while another is in work");

    // a trade is always followed by level updates
    a_trade_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.result_kind == lom_pkg::KIND_TRADE
        |-> !i_out_data.last_result && i_out_data.level_action == lom_pkg::ACT_ADD)
        else $error("trade flagged last or with level action");

    // an invalid-order error is the only result of its order
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.result_kind == lom_pkg::KIND_INVALID
        |-> i_out_data.last_result)
        else $error("invalid-order error not last");
endmodule

bind limit_order_matcher lom_checker u_lom_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_order.valid),
    .i_in_ready  (i_order.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  (o_result.data)
);

// ----- tb/limit_order_matcher_tb.sv -----
// ----------------------------------------------------------------------------
// limit_order_matcher_tb
// Drives limit orders into the matcher and checks every result beat against
// a behavioral price-time priority book kept inside the bench.
// ----------------------------------------------------------------------------
module limit_order_matcher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 1500000;

    logic i_clk;
    logic i_rst_n;

    lom_stream_if #(.T(lom_pkg::t_order))  order_ch ();
    lom_stream_if #(.T(lom_pkg::t_result)) result_ch ();

    limit_order_matcher #(.BOOK_DEPTH(DEPTH)) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_order  (order_ch.sink),
        .o_result (result_ch.source)
    );

    // bench copy of both books, index 0 bid, 1 ask
    logic        bk_valid [2][DEPTH];
    logic [31:0] bk_price [2][DEPTH];
    logic [30:0] bk_qty   [2][DEPTH];
    logic [31:0] bk_time  [2][DEPTH];
    int          bk_rank  [2][DEPTH];

    lom_pkg::t_order  pending_orders[$];
    lom_pkg::t_result expected_results[$];
    int      mismatches;
    int      cycle_count;
    int      orders_sent;
    int      results_seen;
    int      trades_seen;
    logic    quiet;
    logic    stim_done;
    logic    order_taken;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic int best_resting(int s, logic high_first);
        int sel;
        logic better;
        sel = -1;
        for (int i = 0; i < DEPTH; i++) begin
            if (!bk_valid[s][i]) continue;
            if (sel < 0) begin
                sel = i;
                continue;
            end
            if (bk_price[s][i] != bk_price[s][sel])
                better = high_first ? (bk_price[s][i] > bk_price[s][sel])
                                    : (bk_price[s][i] < bk_price[s][sel]);
            else if (bk_time[s][i] != bk_time[s][sel])
                better = bk_time[s][i] < bk_time[s][sel];
            else
                better = bk_rank[s][i] < bk_rank[s][sel];
            if (better) sel = i;
        end
        return sel;
    endfunction

    function automatic void push_result(logic [2:0] k, logic [31:0] p,
                                        logic [30:0] q, logic [1:0] a);
        lom_pkg::t_result r;
        r.result_kind = k;
        r.result_price = p;
        r.result_quantity = q;
        r.level_action = a;
        r.last_result = 1'b0;
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void add_order(lom_pkg::t_order o);
        pending_orders.insert(pending_orders.size(), o);
    endfunction

    // works out every result of one order and updates the bench books
    function automatic void match_order(lom_pkg::t_order o);
        int own, opp, e, slot, count, base;
        logic [30:0] q;
        logic [31:0] rp;
        logic [31:0] touched[$];
        logic [63:0] sum;
        logic dup;
        base = expected_results.size();
        own = int'(o.order_side);
        opp = 1 - own;
        q = o.order_quantity;
        if (o.order_price == 0 || q == 0) begin
            push_result(lom_pkg::KIND_INVALID, '0, '0, lom_pkg::ACT_ADD);
        end else begin
            while (q != 0) begin
                e = best_resting(opp, o.order_side == lom_pkg::SIDE_SELL);
                if (e < 0) break;
                rp = bk_price[opp][e];
                if (o.order_side == lom_pkg::SIDE_BUY ? rp > o.order_price
                                                      : rp < o.order_price)
                    break;
                dup = 1'b0;
                foreach (touched[j]) if (touched[j] == rp) dup = 1'b1;
                if (!dup) touched.insert(touched.size(), rp);
                if (bk_qty[opp][e] > q) begin
                    push_result(lom_pkg::KIND_TRADE, rp, q, lom_pkg::ACT_ADD);
                    bk_qty[opp][e] -= q;
                    q = '0;
                end else begin
                    push_result(lom_pkg::KIND_TRADE, rp, bk_qty[opp][e], lom_pkg::ACT_ADD);
                    q -= bk_qty[opp][e];
                    bk_valid[opp][e] = 1'b0;
                    for (int j = 0; j < DEPTH; j++)
                        if (bk_valid[opp][j] && bk_rank[opp][j] > bk_rank[opp][e])
                            bk_rank[opp][j]--;
                end
            end
            if (q != 0) begin
                slot = -1;
                count = 0;
                for (int i = 0; i < DEPTH; i++) begin
                    if (bk_valid[own][i]) count++;
                    else if (slot < 0) slot = i;
                end
                if (slot < 0) begin
                    push_result(lom_pkg::KIND_FULL, '0, '0, lom_pkg::ACT_ADD);
                end else begin
                    bk_valid[own][slot] = 1'b1;
                    bk_price[own][slot] = o.order_price;
                    bk_qty[own][slot] = q;
                    bk_time[own][slot] = o.order_time;
                    bk_rank[own][slot] = count;
                    push_result(own == 0 ? lom_pkg::KIND_BID : lom_pkg::KIND_ASK,
                                o.order_price, q, lom_pkg::ACT_ADD);
                end
            end
            touched.sort();
            foreach (touched[i]) begin
                sum = '0;
                for (int j = 0; j < DEPTH; j++)
                    if (bk_valid[opp][j] && bk_price[opp][j] == touched[i])
                        sum += 64'(bk_qty[opp][j]);
                if (sum > 64'(lom_pkg::QTY_MAX)) sum = 64'(lom_pkg::QTY_MAX);
                push_result(opp == 0 ? lom_pkg::KIND_BID : lom_pkg::KIND_ASK,
                            touched[i], sum[30:0],
                            sum != 0 ? lom_pkg::ACT_MODIFY : lom_pkg::ACT_DELETE);
            end
        end
        if (expected_results.size() > base)
            expected_results[expected_results.size() - 1].last_result = 1'b1;
    endfunction

    function automatic lom_pkg::t_order make_order(logic s, logic [31:0] p,
                                                   logic [30:0] q, logic [31:0] t);
        lom_pkg::t_order o;
        o.order_side = s;
        o.order_price = p;
        o.order_quantity = q;
        o.order_ident = $urandom;
        o.order_time = t;
        return o;
    endfunction

    // driver: new beat presented at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            order_ch.valid <= 1'b0;
            order_taken = 1'b0;
        end else if (!order_ch.valid || order_taken) begin
            // previous beat was taken at the rising edge just gone, or none shown
            order_taken = 1'b0;
            if (pending_orders.size() > 0 && (quiet || $urandom_range(99) >= 32)) begin
                order_ch.data  <= pending_orders.pop_front();
                order_ch.valid <= 1'b1;
            end else begin
                order_ch.valid <= 1'b0;
            end
        end
        result_ch.ready <= quiet || $urandom_range(99) >= 32;
    end

    // acceptance of a beat on the input side feeds the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && order_ch.valid && order_ch.ready) begin
            order_taken = 1'b1;
            match_order(order_ch.data);
            orders_sent++;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        lom_pkg::t_result got, want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got = result_ch.data;
            results_seen++;
            if (got.result_kind == lom_pkg::KIND_TRADE) trades_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat kind=%0d price=%0d qty=%0d",
                             got.result_kind, got.result_price, got.result_quantity);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp kind=%0d price=%0d qty=%0d act=%0d last=%0d",
                                  " got kind=%0d price=%0d qty=%0d act=%0d last=%0d"},
                                 want.result_kind, want.result_price, want.result_quantity,
                                 want.level_action, want.last_result,
                                 got.result_kind, got.result_price, got.result_quantity,
                                 got.level_action, got.last_result);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int base_px;
        logic s;
        lom_pkg::t_order o;
        i_rst_n = 1'b0;
        order_ch.valid = 1'b0;
        order_ch.data = '0;
        result_ch.ready = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        orders_sent = 0;
        results_seen = 0;
        trades_seen = 0;
        quiet = 1'b0;
        stim_done = 1'b0;
        order_taken = 1'b0;
        foreach (bk_valid[s2, i]) bk_valid[s2][i] = 1'b0;

        // directed: invalid orders, field extremes, full fills, book full
        add_order(make_order(lom_pkg::SIDE_BUY, 32'd0, 31'd5, 32'd1));
        add_order(make_order(lom_pkg::SIDE_SELL, 32'd100, 31'd0, 32'd1));
        add_order(make_order(lom_pkg::SIDE_SELL, 32'hFFFF_FFFF, lom_pkg::QTY_MAX,
                             32'hFFFF_FFFF));
        add_order(make_order(lom_pkg::SIDE_SELL, 32'hFFFF_FFFF, lom_pkg::QTY_MAX,
                             32'hFFFF_FFFF));
        // level total saturates, then a buy clears partly
        add_order(make_order(lom_pkg::SIDE_BUY, 32'hFFFF_FFFF, 31'd10, 32'd0));
        add_order(make_order(lom_pkg::SIDE_BUY, 32'd1, 31'd1, 32'd0));
        add_order(make_order(lom_pkg::SIDE_SELL, 32'd1, 31'd1, 32'd5));
        // equal price and time: earlier arrival wins
        add_order(make_order(lom_pkg::SIDE_SELL, 32'd500, 31'd3, 32'd7));
        add_order(make_order(lom_pkg::SIDE_SELL, 32'd500, 31'd4, 32'd7));
        add_order(make_order(lom_pkg::SIDE_SELL, 32'd400, 31'd2, 32'd9));
        add_order(make_order(lom_pkg::SIDE_BUY, 32'd500, 31'd5, 32'd8));
        add_order(make_order(lom_pkg::SIDE_BUY, 32'd500, 31'd4, 32'd8));
        // sweep all asks with one large buy
        add_order(make_order(lom_pkg::SIDE_BUY, 32'hFFFF_FFFF, lom_pkg::QTY_MAX, 32'd3));
        // fill the bid book and overflow it
        for (int i = 0; i < DEPTH + 2; i++)
            add_order(make_order(lom_pkg::SIDE_BUY, 32'(10 + i), 31'(1 + i), 32'(i)));
        // sell hitting many levels while the bid book is full
        add_order(make_order(lom_pkg::SIDE_SELL, 32'd1, 31'd500, 32'd2));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // random: prices clustered so books cross often, with some noise
        base_px = 1000;
        for (int n = 0; n < 500; n++) begin
            s = 1'($urandom_range(1));
            o = make_order(s, 32'(base_px - 8 + int'($urandom_range(16))),
                           31'($urandom_range(1, 40)), 32'($urandom_range(20)));
            case ($urandom_range(19))
                0: o.order_price = '0;
                1: o.order_quantity = '0;
                2: o.order_price = $urandom;
                3: o.order_quantity = 31'($urandom);
                4: o.order_time = $urandom;
                5: o.order_quantity = 31'($urandom_range(100, 400));
                default: ;
            endcase
            if (n >= 200 && n < 300) quiet = 1'b1;
            else quiet = 1'b0;
            add_order(o);
            // keep the feed queue shallow so the quiet window lines up
            while (pending_orders.size() >= 4) @(posedge i_clk);
        end
        quiet = 1'b0;
        while (pending_orders.size() != 0 || order_ch.valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("covered %0d orders, %0d result beats, %0d trades",
                 orders_sent, results_seen, trades_seen);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("mismatches: %0d", mismatches);
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
